/* rtl/ksbl_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ksbl_pkg
// Shared types and constants of the k-th successor binary lifting block.
// ---------------------------------------------------------------------------
package ksbl_pkg;

  localparam int unsigned NODES   = 1024;
  localparam int unsigned LEVELS  = 20;
  localparam int unsigned NODE_W  = $clog2(NODES);
  localparam int unsigned LEVEL_W = $clog2(LEVELS);
  localparam int unsigned ADDR_W  = LEVEL_W + NODE_W;
  localparam int unsigned DEPTH   = LEVELS * NODES;
  localparam int unsigned CNT_W   = NODE_W + 1;
  localparam int unsigned STEPS_W = 20;
  localparam int unsigned PADDR_W = 3;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(NODES);
  localparam logic [CNT_W-1:0] NODES_CNT      = CNT_W'(NODES);
  localparam logic [LEVEL_W-1:0] LAST_LEVEL   = LEVEL_W'(LEVELS - 1);

  // register index, taken from paddr[2]
  localparam logic REG_NODE_COUNT = 1'b0;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_BUILD = 2'd1,
    MODE_QUERY = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUILD_RD1,
    ST_BUILD_RD2,
    ST_BUILD_WR,
    ST_QUERY,
    ST_QUERY_FIN,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [NODE_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

/* rtl/ksbl_mem.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ksbl_mem
// Jump table: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module ksbl_mem
  import ksbl_pkg::*;
(
  input  logic              clk_i,
  input  mem_req_t          req_i,
  output logic [NODE_W-1:0] rdata_o
);

  logic [NODE_W-1:0] ram [DEPTH];
  logic [NODE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      ram[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= ram[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ksbl_engine.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ksbl_engine
// Sequencer for loads, table builds and queries, with the result register.
// ---------------------------------------------------------------------------
module ksbl_engine
  import ksbl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [CNT_W-1:0]   lim_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [39:0]        s_axis_tdata,   // node, successor, steps
  input  logic [1:0]         s_axis_tuser,   // mode
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [15:0]        m_axis_tdata,   // end_node, zero fill
  output logic [0:0]         m_axis_tuser,   // bad_node
  output mem_req_t           mem_req_o,
  input  logic [NODE_W-1:0]  mem_rdata_i
);

  state_e             state_q, state_d;
  logic [LEVEL_W-1:0] lv_q, lv_d;
  logic [NODE_W-1:0]  idx_q, idx_d;
  logic [NODE_W-1:0]  p_q, p_d;
  logic               pend_q, pend_d;
  logic [STEPS_W-1:0] steps_q, steps_d;
  logic [NODE_W-1:0]  res_node_q, res_node_d;
  logic               res_bad_q, res_bad_d;
  logic               out_valid_q, out_valid_d;
  logic [NODE_W-1:0]  out_node_q, out_node_d;
  logic               out_bad_q, out_bad_d;

  logic [NODE_W-1:0]  in_node;
  logic [NODE_W-1:0]  in_succ;
  logic [STEPS_W-1:0] in_steps;
  logic               accept;
  logic               node_bad;
  logic [NODE_W-1:0]  cur;
  logic [CNT_W-1:0]   idx_next;

  assign in_node  = s_axis_tdata[NODE_W-1:0];
  assign in_succ  = s_axis_tdata[2*NODE_W-1:NODE_W];
  assign in_steps = s_axis_tdata[2*NODE_W+STEPS_W-1:2*NODE_W];
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign node_bad = {1'b0, in_node} >= lim_i;
  assign cur      = pend_q ? mem_rdata_i : p_q;
  assign idx_next = {1'b0, idx_q} + CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lv_q       <= lv_d;
    idx_q      <= idx_d;
    p_q        <= p_d;
    steps_q    <= steps_d;
    res_node_q <= res_node_d;
    res_bad_q  <= res_bad_d;
    out_node_q <= out_node_d;
    out_bad_q  <= out_bad_d;
  end

  always_comb begin
    state_d     = state_q;
    lv_d        = lv_q;
    idx_d       = idx_q;
    p_d         = p_q;
    pend_d      = pend_q;
    steps_d     = steps_q;
    res_node_d  = res_node_q;
    res_bad_d   = res_bad_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_node_d  = out_node_q;
    out_bad_d   = out_bad_q;
    mem_req_o   = '0;
    s_axis_tready = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (accept) begin
          case (s_axis_tuser)
            MODE_LOAD: begin
              if (node_bad) begin
                res_node_d = '0;
                res_bad_d  = 1'b1;
                state_d    = ST_RESULT;
              end else begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = {LEVEL_W'(0), in_node};
                mem_req_o.wdata = in_succ;
              end
            end
            MODE_BUILD: begin
              if (lim_i != '0 && LEVELS > 1) begin
                lv_d    = LEVEL_W'(1);
                idx_d   = '0;
                state_d = ST_BUILD_RD1;
              end
            end
            MODE_QUERY: begin
              if (node_bad) begin
                res_node_d = '0;
                res_bad_d  = 1'b1;
                state_d    = ST_RESULT;
              end else begin
                p_d     = in_node;
                steps_d = in_steps;
                lv_d    = '0;
                pend_d  = 1'b0;
                state_d = ST_QUERY;
              end
            end
            default: ;
          endcase
        end
      end
      ST_BUILD_RD1: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = {lv_q - LEVEL_W'(1), idx_q};
        state_d         = ST_BUILD_RD2;
      end
      ST_BUILD_RD2: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = {lv_q - LEVEL_W'(1), mem_rdata_i};
        state_d         = ST_BUILD_WR;
      end
      ST_BUILD_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = {lv_q, idx_q};
        mem_req_o.wdata = mem_rdata_i;
        state_d         = ST_BUILD_RD1;
        if (idx_next == lim_i) begin
          idx_d = '0;
          if (lv_q == LAST_LEVEL) begin
            state_d = ST_IDLE;
          end else begin
            lv_d = lv_q + LEVEL_W'(1);
          end
        end else begin
          idx_d = idx_next[NODE_W-1:0];
        end
      end
      ST_QUERY: begin
        p_d             = cur;
        pend_d          = steps_q[lv_q];
        mem_req_o.re    = steps_q[lv_q];
        mem_req_o.raddr = {lv_q, cur};
        if (lv_q == LAST_LEVEL) begin
          state_d = ST_QUERY_FIN;
        end else begin
          lv_d = lv_q + LEVEL_W'(1);
        end
      end
      ST_QUERY_FIN: begin
        res_node_d = cur;
        res_bad_d  = 1'b0;
        pend_d     = 1'b0;
        state_d    = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_node_d  = res_node_q;
          out_bad_d   = res_bad_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(16 - NODE_W)'(0), out_node_q};
  assign m_axis_tuser  = out_bad_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == ST_IDLE)
    else $error("input taken outside idle");

  a_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.we |-> (state_q == ST_IDLE || state_q == ST_BUILD_WR))
    else $error("table write from unexpected state");

  a_build_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_BUILD_WR |-> lv_q != '0)
    else $error("build writing level zero");

  a_build_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser == MODE_BUILD && lim_i != '0) |=> state_q == ST_BUILD_RD1)
    else $error("build did not start");

  a_result_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESULT && (!out_valid_q || m_axis_tready)) |=> m_axis_tvalid)
    else $error("result not presented");

endmodule

/* rtl/kth_successor_binary_lifting.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kth_successor_binary_lifting
// Functional graph with a binary lifting jump table answering k-th successor
// requests.
// ---------------------------------------------------------------------------
// One request at a time is processed; the input side is ready only while the
// sequencer is idle, and a finished result waits in an output register so a
// new request may be taken while it is pending. A valid load is written to
// level zero of the table as it is accepted. A query steps through the
// levels from acceptance to the result register, with one jump table read
// through the single read port for each level whose steps bit is set.
// A build makes two dependent reads and one write per entry. A load or query
// on a node at or beyond node_count returns end_node 0 with bad_node set. The
// table holds garbage after reset until loaded and built.
// ---------------------------------------------------------------------------
module kth_successor_binary_lifting
  import ksbl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [39:0]        s_axis_tdata,   // node, successor, steps
  input  logic [1:0]         s_axis_tuser,   // mode
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [15:0]        m_axis_tdata,   // end_node, zero fill
  output logic [0:0]         m_axis_tuser,   // bad_node
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [CNT_W-1:0]  node_count_q, node_count_d;
  logic [CNT_W-1:0]  lim;
  logic              cfg_wr;
  mem_req_t          mem_req;
  logic [NODE_W-1:0] mem_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_NODE_COUNT);

  always_comb begin
    node_count_d = node_count_q;
    if (cfg_wr) begin
      node_count_d = pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
    end else begin
      node_count_q <= node_count_d;
    end
  end

  assign prdata = (paddr[2] == REG_NODE_COUNT) ? {(32 - CNT_W)'(0), node_count_q} : '0;

  // node counts above the table size act as the table size
  assign lim = (node_count_q > NODES_CNT) ? NODES_CNT : node_count_q;

  ksbl_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .lim_i         (lim),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .mem_req_o     (mem_req),
    .mem_rdata_i   (mem_rdata)
  );

  ksbl_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule
